// ===== hw/rtl/scara_fk_pkg.sv =====
// Shared types, constants and arithmetic helpers of the SCARA forward kinematics unit.
`timescale 1ns / 1ps

package scara_fk_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned CORDIC_STEPS   = 24;
  localparam int unsigned VEC_W          = 32;
  localparam int unsigned LEN_W          = 16;
  localparam int unsigned TRIG_W         = 16;
  localparam int unsigned POS_W          = 18;
  localparam int unsigned CFG_AW         = 4;
  localparam int unsigned CFG_DW         = 32;

  localparam logic [1:0] REG_BASE_HEIGHT  = 2'd0;
  localparam logic [1:0] REG_FIRST_LINK   = 2'd1;
  localparam logic [1:0] REG_SECOND_LINK  = 2'd2;
  localparam logic [1:0] REG_AXIS_OFFSET  = 2'd3;

  localparam logic [LEN_W-1:0] BASE_HEIGHT_RST = 16'd8192;
  localparam logic [LEN_W-1:0] FIRST_LINK_RST  = 16'd4096;
  localparam logic [LEN_W-1:0] SECOND_LINK_RST = 16'd4096;
  localparam logic [LEN_W-1:0] AXIS_OFFSET_RST = 16'd205;

  // 1/K of the rotation sequence in Q2.30
  localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [VEC_W-1:0] QUARTER_TURN = 32'sd1073741824;
  localparam logic signed [TRIG_W-1:0] TRIG_ONE = 16'sd16384;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } cordic_vec_t;

  typedef struct packed {
    cordic_vec_t              a;
    cordic_vec_t              b;
    logic                     flip_a;
    logic                     flip_b;
    logic signed [POS_W-1:0]  side;
  } cordic_stage_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] c1;
    logic signed [TRIG_W-1:0] s1;
    logic signed [TRIG_W-1:0] c12;
    logic signed [TRIG_W-1:0] s12;
  } trig_t;

  // atan(2^-i) with a full turn equal to 2^32
  function automatic logic signed [VEC_W-1:0] atan_angle(input int unsigned i);
    logic signed [VEC_W-1:0] r;
    case (i)
      0:       r = 32'sh20000000;
      1:       r = 32'sh12E4051E;
      2:       r = 32'sh09FB385B;
      3:       r = 32'sh051111D4;
      4:       r = 32'sh028B0D43;
      5:       r = 32'sh0145D7E1;
      6:       r = 32'sh00A2F61E;
      7:       r = 32'sh00517C55;
      8:       r = 32'sh0028BE53;
      9:       r = 32'sh00145F2F;
      10:      r = 32'sh000A2F98;
      11:      r = 32'sh000517CC;
      12:      r = 32'sh00028BE6;
      13:      r = 32'sh000145F3;
      14:      r = 32'sh0000A2FA;
      15:      r = 32'sh0000517D;
      16:      r = 32'sh000028BE;
      17:      r = 32'sh0000145F;
      18:      r = 32'sh00000A30;
      19:      r = 32'sh00000518;
      20:      r = 32'sh0000028C;
      21:      r = 32'sh00000146;
      22:      r = 32'sh000000A3;
      23:      r = 32'sh00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // One micro-rotation; steer toward z = 0
  function automatic cordic_vec_t cordic_step(input cordic_vec_t v, input int unsigned i);
    cordic_vec_t r;
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;
    xs = v.x >>> i;
    ys = v.y >>> i;
    if (!v.z[VEC_W-1]) begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - atan_angle(i);
    end else begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + atan_angle(i);
    end
    return r;
  endfunction

  // Q2.30 to Q1.14, round half up, clamp to +-1.0, undo the half-turn fold
  function automatic logic signed [TRIG_W-1:0] trig_round(input logic signed [VEC_W-1:0] v,
                                                          input logic flip);
    logic signed [VEC_W:0]    sum;
    logic signed [VEC_W:0]    shr;
    logic signed [TRIG_W-1:0] r;
    sum = {v[VEC_W-1], v} + 33'sd32768;
    shr = sum >>> 16;
    if (shr > 33'sd16384) begin
      r = TRIG_ONE;
    end else if (shr < -33'sd16384) begin
      r = -TRIG_ONE;
    end else begin
      r = shr[TRIG_W-1:0];
    end
    if (flip) begin
      r = -r;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/scara_forward_kinematics_unit.sv =====
// Top level of the SCARA forward kinematics unit: register port, CORDIC and position math.
`timescale 1ns / 1ps

// Takes one joint sample (q1, q2, d3) per clock whenever start is high; busy stays low, so a
// sample can be issued every cycle. Each sample yields exactly one pose, shown for one cycle
// with result_valid_o high, once the sample has passed through one angle-fold stage, the
// 24 micro-rotation stages of the sine/cosine CORDIC, one rounding stage, one multiply stage
// and one sum/saturate stage. Poses leave in the order the samples arrived and cannot be held
// off. Link lengths are read live from the registers, so change them only while no sample is
// in flight.
module scara_forward_kinematics_unit #(
  parameter int unsigned ANGLE_BITS = scara_fk_pkg::ANGLE_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // register port
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [scara_fk_pkg::CFG_AW-1:0]             paddr,
  input  logic [scara_fk_pkg::CFG_DW-1:0]             pwdata,
  output logic [scara_fk_pkg::CFG_DW-1:0]             prdata,
  output logic                                        pready,
  // sample in
  input  logic                                        start,
  output logic                                        busy,
  input  logic [15:0]                                 joint1_angle_i,
  input  logic [15:0]                                 joint2_angle_i,
  input  logic signed [15:0]                          slide_extension_i,
  // pose out
  output logic                                        result_valid_o,
  output logic signed [scara_fk_pkg::TRIG_W-1:0]      rot_cos_o,
  output logic signed [scara_fk_pkg::TRIG_W-1:0]      rot_sin_o,
  output logic signed [scara_fk_pkg::POS_W-1:0]       pos_x_o,
  output logic signed [scara_fk_pkg::POS_W-1:0]       pos_y_o,
  output logic signed [scara_fk_pkg::POS_W-1:0]       pos_z_o
);
  import scara_fk_pkg::*;

  localparam int unsigned PROD_W = 2 * TRIG_W + 2;
  localparam int unsigned SUM_W  = PROD_W + 1;

  logic [LEN_W-1:0] base_height_q;
  logic [LEN_W-1:0] first_link_q;
  logic [LEN_W-1:0] second_link_q;
  logic [LEN_W-1:0] axis_offset_q;
  logic             cfg_wr;

  logic [ANGLE_BITS-1:0]   q1;
  logic [ANGLE_BITS-1:0]   q12;
  logic signed [POS_W-1:0] pos_z_in;
  logic                    in_valid;

  logic                    cor_valid;
  trig_t                   cor_trig;
  logic signed [POS_W-1:0] cor_side;

  logic signed [LEN_W+1:0] r1;
  logic signed [LEN_W:0]   l2;

  logic signed [PROD_W-1:0] p_xc_q;
  logic signed [PROD_W-1:0] p_xr_q;
  logic signed [PROD_W-1:0] p_ys_q;
  logic signed [PROD_W-1:0] p_yr_q;
  logic signed [TRIG_W-1:0] c12_q;
  logic signed [TRIG_W-1:0] s12_q;
  logic signed [POS_W-1:0]  z_q;
  logic                     mul_vld_q;

  logic                     out_vld_q;
  logic signed [TRIG_W-1:0] rot_cos_q;
  logic signed [TRIG_W-1:0] rot_sin_q;
  logic signed [POS_W-1:0]  pos_x_q;
  logic signed [POS_W-1:0]  pos_y_q;
  logic signed [POS_W-1:0]  pos_z_q;

  // Sum two products, drop 14 fraction bits rounding half up, saturate to the position range
  function automatic logic signed [POS_W-1:0] pos_round_sat(input logic signed [PROD_W-1:0] a,
                                                            input logic signed [PROD_W-1:0] b);
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] shr;
    logic signed [POS_W-1:0] r;
    sum = SUM_W'(a) + SUM_W'(b) + SUM_W'(8192);
    shr = sum >>> 14;
    if (shr > SUM_W'(131071)) begin
      r = 18'sh1FFFF;
    end else if (shr < -SUM_W'(131072)) begin
      r = 18'sh20000;
    end else begin
      r = shr[POS_W-1:0];
    end
    return r;
  endfunction

  // ---------------- register port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_height_q <= BASE_HEIGHT_RST;
      first_link_q  <= FIRST_LINK_RST;
      second_link_q <= SECOND_LINK_RST;
      axis_offset_q <= AXIS_OFFSET_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_BASE_HEIGHT: base_height_q <= pwdata[LEN_W-1:0];
        REG_FIRST_LINK:  first_link_q  <= pwdata[LEN_W-1:0];
        REG_SECOND_LINK: second_link_q <= pwdata[LEN_W-1:0];
        REG_AXIS_OFFSET: axis_offset_q <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BASE_HEIGHT: prdata = {{(CFG_DW-LEN_W){1'b0}}, base_height_q};
      REG_FIRST_LINK:  prdata = {{(CFG_DW-LEN_W){1'b0}}, first_link_q};
      REG_SECOND_LINK: prdata = {{(CFG_DW-LEN_W){1'b0}}, second_link_q};
      REG_AXIS_OFFSET: prdata = {{(CFG_DW-LEN_W){1'b0}}, axis_offset_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------- sample entry ----------------
  assign busy     = 1'b0;
  assign in_valid = start;
  assign q1       = ANGLE_BITS'(joint1_angle_i);
  assign q12      = ANGLE_BITS'(joint1_angle_i) + ANGLE_BITS'(joint2_angle_i);
  // l0 - d3 always fits the position range, no clamp needed
  assign pos_z_in = $signed({2'b00, base_height_q})
                  - $signed({{(POS_W-16){slide_extension_i[15]}}, slide_extension_i});

  scara_fk_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid),
    .angle_a_i (q1),
    .angle_b_i (q12),
    .side_i    (pos_z_in),
    .valid_o   (cor_valid),
    .trig_o    (cor_trig),
    .side_o    (cor_side)
  );

  // ---------------- multiply stage ----------------
  assign r1 = $signed({2'b00, first_link_q}) - $signed({1'b0, axis_offset_q, 1'b0});
  assign l2 = $signed({1'b0, second_link_q});

  always_ff @(posedge clk_i) begin
    p_xc_q <= PROD_W'(l2) * PROD_W'(cor_trig.c12);
    p_xr_q <= PROD_W'(r1) * PROD_W'(cor_trig.c1);
    p_ys_q <= PROD_W'(l2) * PROD_W'(cor_trig.s12);
    p_yr_q <= PROD_W'(r1) * PROD_W'(cor_trig.s1);
    c12_q  <= cor_trig.c12;
    s12_q  <= cor_trig.s12;
    z_q    <= cor_side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= cor_valid;
    end
  end

  // ---------------- sum, round and saturate ----------------
  always_ff @(posedge clk_i) begin
    rot_cos_q <= c12_q;
    rot_sin_q <= s12_q;
    pos_x_q   <= pos_round_sat(p_xc_q, p_xr_q);
    pos_y_q   <= pos_round_sat(p_ys_q, p_yr_q);
    pos_z_q   <= z_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= mul_vld_q;
    end
  end

  assign result_valid_o = out_vld_q;
  assign rot_cos_o      = rot_cos_q;
  assign rot_sin_o      = rot_sin_q;
  assign pos_x_o        = pos_x_q;
  assign pos_y_o        = pos_y_q;
  assign pos_z_o        = pos_z_q;

endmodule

// ===== hw/rtl/scara_fk_cordic.sv =====
// Dual-lane pipelined rotation CORDIC, one micro-rotation per register stage.
`timescale 1ns / 1ps

module scara_fk_cordic #(
  parameter int unsigned ANGLE_BITS = scara_fk_pkg::ANGLE_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  input  logic [ANGLE_BITS-1:0]                         angle_a_i,
  input  logic [ANGLE_BITS-1:0]                         angle_b_i,
  input  logic signed [scara_fk_pkg::POS_W-1:0]         side_i,
  output logic                                          valid_o,
  output scara_fk_pkg::trig_t                           trig_o,
  output logic signed [scara_fk_pkg::POS_W-1:0]         side_o
);
  import scara_fk_pkg::*;

  localparam int unsigned PAD_BITS = VEC_W - ANGLE_BITS;

  cordic_stage_t st_q [CORDIC_STEPS+1];
  logic          vld_q [CORDIC_STEPS+1];

  cordic_vec_t   pre_a;
  cordic_vec_t   pre_b;
  logic          flip_a;
  logic          flip_b;

  trig_t                   trig_q;
  logic                    vld_out_q;
  logic signed [POS_W-1:0] side_q;

  // Fold the angle into [-quarter, +quarter] turn and remember the half-turn flip
  function automatic cordic_vec_t prerotate(input logic [ANGLE_BITS-1:0] ang,
                                            output logic flip);
    cordic_vec_t r;
    logic signed [VEC_W-1:0] z;
    z = $signed({ang, {PAD_BITS{1'b0}}});
    flip = (z > QUARTER_TURN) || (z < -QUARTER_TURN);
    if (flip) begin
      z[VEC_W-1] = ~z[VEC_W-1];
    end
    r.x = CORDIC_GAIN;
    r.y = '0;
    r.z = z;
    return r;
  endfunction

  always_comb begin
    pre_a = prerotate(angle_a_i, flip_a);
    pre_b = prerotate(angle_b_i, flip_b);
  end

  always_ff @(posedge clk_i) begin
    st_q[0].a      <= pre_a;
    st_q[0].b      <= pre_b;
    st_q[0].flip_a <= flip_a;
    st_q[0].flip_b <= flip_b;
    st_q[0].side   <= side_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    cordic_stage_t stage_d;

    always_comb begin
      stage_d   = st_q[g];
      stage_d.a = cordic_step(st_q[g].a, g);
      stage_d.b = cordic_step(st_q[g].b, g);
    end

    always_ff @(posedge clk_i) begin
      st_q[g+1] <= stage_d;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else begin
        vld_q[g+1] <= vld_q[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    trig_q.c1  <= trig_round(st_q[CORDIC_STEPS].a.x, st_q[CORDIC_STEPS].flip_a);
    trig_q.s1  <= trig_round(st_q[CORDIC_STEPS].a.y, st_q[CORDIC_STEPS].flip_a);
    trig_q.c12 <= trig_round(st_q[CORDIC_STEPS].b.x, st_q[CORDIC_STEPS].flip_b);
    trig_q.s12 <= trig_round(st_q[CORDIC_STEPS].b.y, st_q[CORDIC_STEPS].flip_b);
    side_q     <= st_q[CORDIC_STEPS].side;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[CORDIC_STEPS];
    end
  end

  assign valid_o = vld_out_q;
  assign trig_o  = trig_q;
  assign side_o  = side_q;

endmodule

// ===== verif/scara_fk_pose_checker.sv =====
// Pose checker for the SCARA forward kinematics unit: tracks registers, predicts and compares poses.
`timescale 1ns / 1ps

module scara_fk_pose_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel_i,
  input  logic                                   penable_i,
  input  logic                                   pwrite_i,
  input  logic [scara_fk_pkg::CFG_AW-1:0]        paddr_i,
  input  logic [scara_fk_pkg::CFG_DW-1:0]        pwdata_i,
  input  logic [scara_fk_pkg::CFG_DW-1:0]        prdata_i,
  input  logic                                   pready_i,
  input  logic                                   start_i,
  input  logic                                   busy_i,
  input  logic [15:0]                            joint1_angle_i,
  input  logic [15:0]                            joint2_angle_i,
  input  logic signed [15:0]                     slide_extension_i,
  input  logic                                   result_valid_i,
  input  logic signed [scara_fk_pkg::TRIG_W-1:0] rot_cos_i,
  input  logic signed [scara_fk_pkg::TRIG_W-1:0] rot_sin_i,
  input  logic signed [scara_fk_pkg::POS_W-1:0]  pos_x_i,
  input  logic signed [scara_fk_pkg::POS_W-1:0]  pos_y_i,
  input  logic signed [scara_fk_pkg::POS_W-1:0]  pos_z_i,
  output int                                     fail_count_o,
  output int                                     poses_pending_o,
  output int                                     poses_checked_o
);

  localparam longint GAIN_Q30 = 652032874;
  localparam longint UNIT_Q14 = 16384;
  localparam longint POS_HI   = 131071;
  localparam longint POS_LO   = -131072;

  typedef struct packed {
    logic signed [scara_fk_pkg::TRIG_W-1:0] rot_cos;
    logic signed [scara_fk_pkg::TRIG_W-1:0] rot_sin;
    logic signed [scara_fk_pkg::POS_W-1:0]  pos_x;
    logic signed [scara_fk_pkg::POS_W-1:0]  pos_y;
    logic signed [scara_fk_pkg::POS_W-1:0]  pos_z;
  } pose_t;

  // atan(2^-k), full turn = 2^32
  longint micro_angle [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  logic [15:0] base_height;
  logic [15:0] first_link;
  logic [15:0] second_link;
  logic [15:0] axis_offset;

  pose_t expected_poses [$];
  pose_t seen_pose;
  pose_t want_pose;
  logic [15:0] read_value;

  initial begin
    fail_count_o    = 0;
    poses_pending_o = 0;
    poses_checked_o = 0;
  end

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Rotation CORDIC on a 32-bit phase; outputs rounded to Q1.14
  function automatic void cordic_sin_cos(input logic [31:0] phase, output longint c,
                                         output longint s);
    longint z;
    longint x;
    longint y;
    longint nx;
    bit     flip;
    z    = longint'({32'd0, phase});
    x    = GAIN_Q30;
    y    = 0;
    flip = 1'b0;
    if (z >= (longint'(1) << 31)) z -= (longint'(1) << 32);
    // fold into the right half-plane, negate at the end
    if (z > (longint'(1) << 30)) begin
      z -= (longint'(1) << 31);
      flip = 1'b1;
    end else if (z < -(longint'(1) << 30)) begin
      z += (longint'(1) << 31);
      flip = 1'b1;
    end
    for (int k = 0; k < 24; k++) begin
      if (z >= 0) begin
        nx = x - (y >>> k);
        y  = y + (x >>> k);
        z  = z - micro_angle[k];
      end else begin
        nx = x + (y >>> k);
        y  = y - (x >>> k);
        z  = z + micro_angle[k];
      end
      x = nx;
    end
    x = sat((x + 32768) >>> 16, -UNIT_Q14, UNIT_Q14);
    y = sat((y + 32768) >>> 16, -UNIT_Q14, UNIT_Q14);
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic pose_t predict_pose(input logic [15:0] q1, input logic [15:0] q2,
                                         input logic signed [15:0] d3);
    logic [15:0] q12;
    longint      c1;
    longint      s1;
    longint      c12;
    longint      s12;
    longint      eff_link;
    longint      l2;
    longint      xv;
    longint      yv;
    longint      zv;
    pose_t       p;
    q12 = q1 + q2;
    cordic_sin_cos({q1, 16'h0000}, c1, s1);
    cordic_sin_cos({q12, 16'h0000}, c12, s12);
    eff_link = longint'(first_link) - 2 * longint'(axis_offset);
    l2       = longint'(second_link);
    xv = sat((l2 * c12 + eff_link * c1 + 8192) >>> 14, POS_LO, POS_HI);
    yv = sat((l2 * s12 + eff_link * s1 + 8192) >>> 14, POS_LO, POS_HI);
    zv = sat(longint'(base_height) - longint'(d3), POS_LO, POS_HI);
    p.rot_cos = c12[15:0];
    p.rot_sin = s12[15:0];
    p.pos_x   = xv[17:0];
    p.pos_y   = yv[17:0];
    p.pos_z   = zv[17:0];
    return p;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count_o < 40) $display("MISMATCH @%0t: %s", $time, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_height <= scara_fk_pkg::BASE_HEIGHT_RST;
      first_link  <= scara_fk_pkg::FIRST_LINK_RST;
      second_link <= scara_fk_pkg::SECOND_LINK_RST;
      axis_offset <= scara_fk_pkg::AXIS_OFFSET_RST;
      expected_poses.delete();
      poses_pending_o = 0;
    end else begin
      if (psel_i && penable_i && pready_i && pwrite_i) begin
        case (paddr_i[3:2])
          scara_fk_pkg::REG_BASE_HEIGHT: base_height <= pwdata_i[15:0];
          scara_fk_pkg::REG_FIRST_LINK:  first_link  <= pwdata_i[15:0];
          scara_fk_pkg::REG_SECOND_LINK: second_link <= pwdata_i[15:0];
          default:                       axis_offset <= pwdata_i[15:0];
        endcase
      end
      if (psel_i && penable_i && pready_i && !pwrite_i) begin
        case (paddr_i[3:2])
          scara_fk_pkg::REG_BASE_HEIGHT: read_value = base_height;
          scara_fk_pkg::REG_FIRST_LINK:  read_value = first_link;
          scara_fk_pkg::REG_SECOND_LINK: read_value = second_link;
          default:                       read_value = axis_offset;
        endcase
        if (prdata_i !== {16'h0000, read_value})
          report_mismatch($sformatf("register read at 0x%0h got 0x%0h want 0x%0h",
                                    paddr_i, prdata_i, read_value));
      end
      // registers hold their old value here, as the base height does inside the block
      if (start_i && !busy_i)
        expected_poses.push_back(predict_pose(joint1_angle_i, joint2_angle_i,
                                              slide_extension_i));
      if (result_valid_i) begin
        seen_pose = '{rot_cos_i, rot_sin_i, pos_x_i, pos_y_i, pos_z_i};
        if (expected_poses.size() == 0) begin
          report_mismatch("pose with no sample outstanding");
        end else begin
          want_pose = expected_poses.pop_front();
          poses_checked_o++;
          if (seen_pose.rot_cos !== want_pose.rot_cos)
            report_mismatch($sformatf("rot_cos got %0d want %0d",
                                      seen_pose.rot_cos, want_pose.rot_cos));
          if (seen_pose.rot_sin !== want_pose.rot_sin)
            report_mismatch($sformatf("rot_sin got %0d want %0d",
                                      seen_pose.rot_sin, want_pose.rot_sin));
          if (seen_pose.pos_x !== want_pose.pos_x)
            report_mismatch($sformatf("pos_x got %0d want %0d",
                                      seen_pose.pos_x, want_pose.pos_x));
          if (seen_pose.pos_y !== want_pose.pos_y)
            report_mismatch($sformatf("pos_y got %0d want %0d",
                                      seen_pose.pos_y, want_pose.pos_y));
          if (seen_pose.pos_z !== want_pose.pos_z)
            report_mismatch($sformatf("pos_z got %0d want %0d",
                                      seen_pose.pos_z, want_pose.pos_z));
        end
      end
      poses_pending_o = expected_poses.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the SCARA forward kinematics unit: stimulus, register setup and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 100;

  logic                                   clk_i   = 1'b0;
  logic                                   rst_ni  = 1'b0;
  logic                                   psel    = 1'b0;
  logic                                   penable = 1'b0;
  logic                                   pwrite  = 1'b0;
  logic [scara_fk_pkg::CFG_AW-1:0]        paddr   = '0;
  logic [scara_fk_pkg::CFG_DW-1:0]        pwdata  = '0;
  logic [scara_fk_pkg::CFG_DW-1:0]        prdata;
  logic                                   pready;
  logic                                   start   = 1'b0;
  logic                                   busy;
  logic [15:0]                            joint1_angle    = '0;
  logic [15:0]                            joint2_angle    = '0;
  logic signed [15:0]                     slide_extension = '0;
  logic                                   result_valid;
  logic signed [scara_fk_pkg::TRIG_W-1:0] rot_cos;
  logic signed [scara_fk_pkg::TRIG_W-1:0] rot_sin;
  logic signed [scara_fk_pkg::POS_W-1:0]  pos_x;
  logic signed [scara_fk_pkg::POS_W-1:0]  pos_y;
  logic signed [scara_fk_pkg::POS_W-1:0]  pos_z;

  int fail_count;
  int poses_pending;
  int poses_checked;
  bit idle_on;
  int idle_pct;
  logic [15:0] link_cfg [4];

  always #1 clk_i = ~clk_i;

  scara_forward_kinematics_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .start             (start),
    .busy              (busy),
    .joint1_angle_i    (joint1_angle),
    .joint2_angle_i    (joint2_angle),
    .slide_extension_i (slide_extension),
    .result_valid_o    (result_valid),
    .rot_cos_o         (rot_cos),
    .rot_sin_o         (rot_sin),
    .pos_x_o           (pos_x),
    .pos_y_o           (pos_y),
    .pos_z_o           (pos_z)
  );

  scara_fk_pose_checker pose_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .prdata_i          (prdata),
    .pready_i          (pready),
    .start_i           (start),
    .busy_i            (busy),
    .joint1_angle_i    (joint1_angle),
    .joint2_angle_i    (joint2_angle),
    .slide_extension_i (slide_extension),
    .result_valid_i    (result_valid),
    .rot_cos_i         (rot_cos),
    .rot_sin_i         (rot_sin),
    .pos_x_i           (pos_x),
    .pos_y_i           (pos_y),
    .pos_z_i           (pos_z),
    .fail_count_o      (fail_count),
    .poses_pending_o   (poses_pending),
    .poses_checked_o   (poses_checked)
  );

  task automatic reg_access(input logic [1:0] idx, input bit wr, input logic [15:0] val);
    logic [15:0] junk;
    // upper data bits are don't-care for the 16-bit registers
    junk = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'h0000;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Angles biased toward quadrant boundaries, where the fold switches
  function automatic logic [15:0] pick_angle();
    logic [15:0] a;
    if ($urandom_range(0, 3) == 0) begin
      a = 16'($urandom_range(0, 3)) << 14;
      a = a + 16'($urandom_range(0, 2)) - 16'd1;
    end else begin
      a = 16'($urandom);
    end
    return a;
  endfunction

  function automatic logic signed [15:0] pick_slide();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_pose(input logic [15:0] q1, input logic [15:0] q2,
                           input logic signed [15:0] d3);
    if (idle_on && $urandom_range(0, 99) < idle_pct) begin
      start           <= 1'b0;
      joint1_angle    <= 16'($urandom);
      joint2_angle    <= 16'($urandom);
      slide_extension <= 16'($urandom);
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    start           <= 1'b1;
    joint1_angle    <= q1;
    joint2_angle    <= q2;
    slide_extension <= d3;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Hold off the sender until every outstanding pose has come back
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (poses_pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    idle_on  = 1'b1;
    idle_pct = 30;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values
    for (int r = 0; r < 4; r++) reg_access(r[1:0], 1'b0, 16'h0000);

    // quadrant edges, wrap of the angle sum, slide extremes
    send_pose(16'h0000, 16'h0000, 16'sh0000);
    send_pose(16'h4000, 16'h0000, 16'sh7FFF);
    send_pose(16'h4001, 16'h0000, 16'sh8000);
    send_pose(16'h3FFF, 16'h0001, 16'shFFFF);
    send_pose(16'h8000, 16'h0000, 16'sh0001);
    send_pose(16'h7FFF, 16'h0001, 16'sh1000);
    send_pose(16'h8001, 16'h7FFF, 16'shF000);
    send_pose(16'hBFFF, 16'h0000, 16'sh2000);
    send_pose(16'hC000, 16'h0000, 16'sh0000);
    send_pose(16'hC001, 16'h0000, 16'sh7FFF);
    send_pose(16'hC000, 16'h8000, 16'sh8000);
    send_pose(16'hFFFF, 16'hFFFF, 16'sh0000);
    send_pose(16'h0001, 16'hFFFF, 16'sh5555);
    send_pose(16'h2000, 16'h2000, 16'shAAAA);
    send_pose(16'h6000, 16'hA000, 16'sh0000);
    send_pose(16'hE000, 16'h4000, 16'sh0CCD);
    send_pose(16'h5555, 16'hAAAA, 16'sh3333);
    send_pose(16'hAAAA, 16'h5555, 16'shCCCC);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      // order: base height, first link, second link, axis offset
      case (ph)
        0: link_cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000};
        1: link_cfg = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF};
        2: link_cfg = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
        3: link_cfg = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000};
        default: begin
          for (int r = 0; r < 4; r++) link_cfg[r] = 16'($urandom);
        end
      endcase
      reg_access(scara_fk_pkg::REG_BASE_HEIGHT, 1'b1, link_cfg[0]);
      reg_access(scara_fk_pkg::REG_FIRST_LINK,  1'b1, link_cfg[1]);
      reg_access(scara_fk_pkg::REG_SECOND_LINK, 1'b1, link_cfg[2]);
      reg_access(scara_fk_pkg::REG_AXIS_OFFSET, 1'b1, link_cfg[3]);
      for (int r = 0; r < 4; r++) reg_access(r[1:0], 1'b0, 16'h0000);

      idle_pct = $urandom_range(5, 40);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // alternate stretches with and without gaps; none in the closing phase
        if (n % 25 == 0) idle_on = (ph != PHASES - 1) && ($urandom_range(0, 2) != 0);
        send_pose(pick_angle(), pick_angle(), pick_slide());
      end
      drain();
    end

    // let any stray pose show up
    repeat (40) @(posedge clk_i);
    $display("Checked %0d poses across reset values and %0d register settings,", poses_checked,
             PHASES);
    $display("including saturated positions, a negative effective link and quadrant edges.");
    if (fail_count == 0) begin
      $display("scara_forward_kinematics_unit verification clean");
    end else begin
      $display("scara_forward_kinematics_unit verification failed");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("Timeout with %0d poses outstanding", poses_pending);
    $display("scara_forward_kinematics_unit verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/scara_fk_pkg.sv
hw/rtl/scara_fk_cordic.sv
hw/rtl/scara_forward_kinematics_unit.sv
verif/scara_fk_pose_checker.sv
verif/tb.sv
